@@ design/pdf_pkg.sv @@
`timescale 1ns / 1ps

package pdf_pkg;

  localparam int unsigned HASH_W            = 32;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned HISTORY_DEPTH_DEF = 16;
  localparam logic [HASH_W-1:0] HASH_SEED   = 32'd5381;
  localparam int unsigned HASH_SHIFT        = 5;

  typedef logic [HASH_W-1:0] hash_t;

  // Shared broadcast to every history cell
  typedef struct packed {
    logic  shift;
    hash_t probe;
  } cell_ctrl_t;

  function automatic hash_t djb2_step(hash_t h, logic [BYTE_W-1:0] b);
    djb2_step = (h << HASH_SHIFT) + h + hash_t'(b);
  endfunction

endpackage

@@ design/pdf_hash_acc.sv @@
`timescale 1ns / 1ps

module pdf_hash_acc
  import pdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  logic              last,
  input  logic [BYTE_W-1:0] data_byte,
  output hash_t             hash_upd
);

  hash_t running_hash;

  assign hash_upd = djb2_step(running_hash, data_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= HASH_SEED;
    end else if (take) begin
      running_hash <= last ? HASH_SEED : hash_upd;
    end
  end

endmodule

@@ design/pdf_cell.sv @@
`timescale 1ns / 1ps

module pdf_cell
  import pdf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cell_ctrl_t ctrl,
  input  hash_t      hash_in,
  output hash_t      hash_out,
  output logic       match
);

  hash_t stored;

  assign hash_out = stored;

  always_ff @(posedge clk) begin
    if (rst) begin
      stored <= '0;
      match  <= 1'b0;
    end else begin
      match <= (stored == ctrl.probe);
      if (ctrl.shift) begin
        stored <= hash_in;
      end
    end
  end

endmodule

@@ design/packet_duplicate_filter.sv @@
`timescale 1ns / 1ps

// packet_duplicate_filter
//
// Slave stream: one message byte per transaction, tdata[7:0] = data_byte,
// tlast marks the final byte. Master stream: one transaction per message,
// tdata[31:0] = message_hash, tuser[0] = is_duplicate.
//
// Non-final bytes are taken one per cycle. The final byte closes the djb2
// hash; the history cells compare it in the next cycle, their match flags
// are registered, and the OR of those flags is loaded with the hash into
// the output register. s_tready is low from the final byte's transaction
// until that load, so no byte of the next message is taken before then,
// a wait set by the cell row's registered compare and match reduction.
//
// History is a row of HISTORY_DEPTH cells; a non-duplicate hash enters
// the first cell and each cell passes its value down; the oldest falls off.
// Reset clears the running hash to its seed, all cells to zero and the
// output register to empty. If m_tready is low with a result pending, the
// next message's result waits and s_tready stays low until it can be loaded.

module packet_duplicate_filter
  import pdf_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] message_hash
  output logic [0:0]  m_tuser    // [0] is_duplicate
);

  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_CMP  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;

  logic [1:0]               phase;
  hash_t                    final_hash;
  hash_t                    hash_upd;
  logic                     take;
  logic                     load_out;
  logic                     dup;
  cell_ctrl_t               ctrl;
  hash_t                    chain [HISTORY_DEPTH+1];
  logic [HISTORY_DEPTH-1:0] match_vec;

  assign s_tready = (phase == PH_IDLE);
  assign take     = s_tvalid && s_tready;
  assign dup      = |match_vec;
  assign load_out = (phase == PH_DONE) && (!m_tvalid || m_tready);

  assign ctrl = '{shift: load_out && !dup, probe: final_hash};

  pdf_hash_acc u_acc (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .last      (s_tlast),
    .data_byte (s_tdata),
    .hash_upd  (hash_upd)
  );

  assign chain[0] = final_hash;

  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    pdf_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .hash_in  (chain[i]),
      .hash_out (chain[i+1]),
      .match    (match_vec[i])
    );
  end

  always_ff @(posedge clk) begin
    if (take && s_tlast) begin
      final_hash <= hash_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else begin
      case (phase)
        PH_IDLE: begin
          if (take && s_tlast) begin
            phase <= PH_CMP;
          end
        end
        PH_CMP: begin
          phase <= PH_DONE;
        end
        PH_DONE: begin
          if (load_out) begin
            phase <= PH_IDLE;
          end
        end
        default: begin
          phase <= PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata    <= final_hash;
      m_tuser[0] <= dup;
    end
  end

endmodule

@@ design/pdf_checker.sv @@
`timescale 1ns / 1ps

module pdf_prop_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic [0:0]  m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready)
    else $error("byte taken during hash compare");

  a_result_due: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tlast |-> ##3 m_tvalid)
    else $error("no result pending three edges after final byte");

endmodule

bind packet_duplicate_filter pdf_prop_checker u_pdf_prop_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
